// ===== hw/rtl/fakc_pkg.sv =====
`default_nettype none

package fakc_pkg;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned SLOT_W = 8;
  localparam int unsigned OP_W   = 2;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [KEY_W-1:0] key;
  } cmd_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fifo_associative_key_cache.sv =====
// Channel   Direction  Ports                 Transfer
// command   in         start, busy, cmd_i    start high while busy low
// result    out        done_o, res_o         one-cycle strobe, no backpressure
//
// Lookup: sequential tag scan through one memory read port, one slot per cycle,
//   through the last slot at most (stops early on the lowest matching slot).
// Insert: free stack / age queue read, then tag and queue write.
// Flush: per active slot an age queue read, then a tag clear and free stack push.
// After reset a clearing pass over all ENTRIES slots fills the free stack and clears
//   the tag memory; busy is high meanwhile. The result shows one cycle after
//   the last work cycle and the next word may be taken in that same cycle.
`default_nettype none

module fifo_associative_key_cache
  import fakc_pkg::*;
#(
  parameter int unsigned ENTRIES = 256
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire cmd_t cmd_i,
  output logic      done_o,
  output res_t      res_o
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam int unsigned TAG_W = KEY_W + 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(ENTRIES);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_LOOK = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_FLRD = 3'd4;
  localparam logic [2:0] S_FLWR = 3'd5;

  function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] a, logic [CNT_W-1:0] b);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(a) + SUM_W'(b);
    if (sum >= SUM_W'(ENTRIES)) begin
      sum = sum - SUM_W'(ENTRIES);
    end
    return sum[IDX_W-1:0];
  endfunction

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] scan_q, scan_d;
  logic             rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0] free_count_q, free_count_d;
  logic [IDX_W-1:0] age_head_q, age_head_d;
  logic [CNT_W-1:0] age_count_q, age_count_d;
  logic             done_q, done_d;
  logic [KEY_W-1:0] key_q, key_d;
  res_t             res_q, res_d;

  logic [TAG_W-1:0] tag_mem [ENTRIES];
  logic [IDX_W-1:0] free_mem [ENTRIES];
  logic [IDX_W-1:0] age_mem [ENTRIES];

  logic [TAG_W-1:0] tag_rdata_q;
  logic [IDX_W-1:0] fs_rdata_q;
  logic [IDX_W-1:0] aq_rdata_q;

  logic             tag_we;
  logic [IDX_W-1:0] tag_waddr;
  logic [TAG_W-1:0] tag_wdata;
  logic             fs_we;
  logic [IDX_W-1:0] fs_waddr;
  logic [IDX_W-1:0] fs_wdata;
  logic             aq_we;
  logic [IDX_W-1:0] aq_waddr;
  logic [IDX_W-1:0] fs_raddr;
  logic [CNT_W-1:0] fc_dec;

  logic             free_avail;
  logic             ins_ok;
  logic [IDX_W-1:0] ins_slot;
  logic [IDX_W-1:0] head_mid;
  logic [CNT_W-1:0] cnt_mid;
  logic [IDX_W-1:0] app_idx;
  logic             app_ok;
  logic             tag_match;

  assign fc_dec     = free_count_q - CNT_W'(1);
  assign fs_raddr   = fc_dec[IDX_W-1:0];
  assign free_avail = (free_count_q != '0);
  assign ins_ok     = free_avail || (age_count_q != '0);
  assign ins_slot   = free_avail ? fs_rdata_q : aq_rdata_q;
  assign head_mid   = free_avail ? age_head_q : wrap_add(age_head_q, CNT_W'(1));
  assign cnt_mid    = free_avail ? age_count_q : (age_count_q - CNT_W'(1));
  assign app_idx    = wrap_add(head_mid, cnt_mid);
  assign app_ok     = (cnt_mid < FULL);
  assign tag_match  = rd_vld_q && tag_rdata_q[KEY_W] && (tag_rdata_q[KEY_W-1:0] == key_q);

  // memory write ports
  always_comb begin
    tag_we    = 1'b0;
    tag_waddr = ins_slot;
    tag_wdata = {1'b1, key_q};
    fs_we     = 1'b0;
    fs_waddr  = free_count_q[IDX_W-1:0];
    fs_wdata  = aq_rdata_q;
    aq_we     = 1'b0;
    aq_waddr  = app_idx;
    unique case (state_q)
      S_INIT: begin
        tag_we    = 1'b1;
        tag_waddr = scan_q;
        tag_wdata = '0;
        fs_we     = 1'b1;
        fs_waddr  = scan_q;
        fs_wdata  = scan_q;
      end
      S_INS: begin
        tag_we = ins_ok;
        aq_we  = ins_ok && app_ok;
      end
      S_FLWR: begin
        tag_we    = 1'b1;
        tag_waddr = aq_rdata_q;
        tag_wdata = '0;
        fs_we     = (free_count_q < FULL);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    scan_d       = scan_q;
    rd_vld_d     = rd_vld_q;
    rd_idx_d     = rd_idx_q;
    free_count_d = free_count_q;
    age_head_d   = age_head_q;
    age_count_d  = age_count_q;
    done_d       = 1'b0;
    key_d        = key_q;
    res_d        = res_q;
    unique case (state_q)
      S_INIT: begin
        scan_d = scan_q + IDX_W'(1);
        if (scan_q == LAST) begin
          scan_d  = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          key_d = cmd_i.key;
          res_d = '0;
          unique case (cmd_i.operation)
            OP_LOOKUP: begin
              state_d  = S_LOOK;
              scan_d   = '0;
              rd_vld_d = 1'b0;
            end
            OP_INSERT: state_d = S_INS;
            OP_FLUSH:  state_d = S_FLRD;
            default:   done_d  = 1'b1;
          endcase
        end
      end
      S_LOOK: begin
        rd_vld_d = 1'b1;
        rd_idx_d = scan_q;
        if (scan_q != LAST) begin
          scan_d = scan_q + IDX_W'(1);
        end
        if (tag_match) begin
          res_d.hit  = 1'b1;
          res_d.slot = SLOT_W'(rd_idx_q);
          done_d     = 1'b1;
          state_d    = S_IDLE;
        end else if (rd_vld_q && (rd_idx_q == LAST)) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_INS: begin
        if (ins_ok) begin
          free_count_d  = free_avail ? fc_dec : free_count_q;
          age_head_d    = head_mid;
          age_count_d   = app_ok ? (cnt_mid + CNT_W'(1)) : cnt_mid;
          res_d.slot    = SLOT_W'(ins_slot);
          res_d.evicted = !free_avail;
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_FLRD: begin
        if (age_count_q == '0) begin
          age_head_d = '0;
          done_d     = 1'b1;
          state_d    = S_IDLE;
        end else begin
          state_d = S_FLWR;
        end
      end
      S_FLWR: begin
        age_head_d  = wrap_add(age_head_q, CNT_W'(1));
        age_count_d = age_count_q - CNT_W'(1);
        if (free_count_q < FULL) begin
          free_count_d = free_count_q + CNT_W'(1);
        end
        state_d = S_FLRD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      scan_q       <= '0;
      rd_vld_q     <= 1'b0;
      rd_idx_q     <= '0;
      free_count_q <= FULL;
      age_head_q   <= '0;
      age_count_q  <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      scan_q       <= scan_d;
      rd_vld_q     <= rd_vld_d;
      rd_idx_q     <= rd_idx_d;
      free_count_q <= free_count_d;
      age_head_q   <= age_head_d;
      age_count_q  <= age_count_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[tag_waddr] <= tag_wdata;
    end
    tag_rdata_q <= tag_mem[scan_q];
  end

  always_ff @(posedge clk_i) begin
    if (fs_we) begin
      free_mem[fs_waddr] <= fs_wdata;
    end
    fs_rdata_q <= free_mem[fs_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (aq_we) begin
      age_mem[aq_waddr] <= ins_slot;
    end
    aq_rdata_q <= age_mem[age_head_q];
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // every slot is either on the free stack or in the age queue
  a_slot_conservation: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SUM_W'(free_count_q) + SUM_W'(age_count_q)) == SUM_W'(ENTRIES))
    else $error("free and active counts do not add up to the slot count");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.hit) |-> !res_o.evicted)
    else $error("lookup hit reported an eviction");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i.operation == OP_LOOKUP || cmd_i.operation == OP_INSERT ||
     cmd_i.operation == OP_FLUSH)) |=> busy)
    else $error("accepted word did not start work");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

module testbench
  import fakc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRIES = 256;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    cmd_t word;
    bit   typed;
    res_t res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  cmd_t cmd_word;
  logic done;
  res_t result_word;

  fifo_associative_key_cache #(
    .ENTRIES(ENTRIES)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .cmd_i (cmd_word),
    .done_o(done),
    .res_o (result_word)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // cache state as predicted
  logic [KEY_W-1:0]  tag_of  [ENTRIES];
  bit                live    [ENTRIES];
  logic [SLOT_W-1:0] free_top[ENTRIES];
  logic [SLOT_W-1:0] fifo_ord[ENTRIES];
  int unsigned       free_depth;
  int unsigned       fifo_head;
  int unsigned       fifo_depth;

  res_t              pending_results[$];
  logic [KEY_W-1:0]  recent_keys[$];
  stim_row_t         directed_rows[$];
  int unsigned       mismatches = 0;
  res_t              oldest_res;

  function automatic res_t cache_predict(input cmd_t c);
    res_t        r;
    int unsigned victim;
    bit          found;
    r = '0;
    found = 1'b0;
    case (c.operation)
      OP_LOOKUP: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!found && live[i] && tag_of[i] == c.key) begin
            found = 1'b1;
            r.hit = 1'b1;
            r.slot = SLOT_W'(i);
          end
        end
      end
      OP_INSERT: begin
        if (free_depth > 0) begin
          free_depth--;
          victim = 32'(free_top[free_depth]);
          found = 1'b1;
        end else if (fifo_depth > 0) begin
          victim = 32'(fifo_ord[fifo_head]);
          fifo_head = (fifo_head + 1) % ENTRIES;
          fifo_depth--;
          live[victim] = 1'b0;
          r.evicted = 1'b1;
          found = 1'b1;
        end
        if (found) begin
          tag_of[victim] = c.key;
          live[victim] = 1'b1;
          fifo_ord[(fifo_head + fifo_depth) % ENTRIES] = SLOT_W'(victim);
          fifo_depth++;
          r.slot = SLOT_W'(victim);
        end
      end
      OP_FLUSH: begin
        while (fifo_depth > 0) begin
          victim = 32'(fifo_ord[fifo_head]);
          fifo_head = (fifo_head + 1) % ENTRIES;
          fifo_depth--;
          live[victim] = 1'b0;
          if (free_depth < ENTRIES) begin
            free_top[free_depth] = SLOT_W'(victim);
            free_depth++;
          end
        end
        fifo_head = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_word(input cmd_t c, input bit use_typed, input res_t typed_res,
                           input bit may_idle);
    res_t predicted;
    start = 1'b1;
    cmd_word = c;
    do @(posedge clk_i); while (busy);
    predicted = cache_predict(c);
    pending_results.push_back(use_typed ? typed_res : predicted);
    if (c.operation == OP_INSERT) begin
      recent_keys.push_back(c.key);
      if (recent_keys.size() > 64) void'(recent_keys.pop_front());
    end
    @(negedge clk_i);
    if (may_idle && $urandom_range(0, 5) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
  endtask

  task automatic drain_results();
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic add_row(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                         input bit typed, input logic hit, input int unsigned slot,
                         input logic evicted);
    stim_row_t row;
    row.word.operation = op;
    row.word.key = key;
    row.typed = typed;
    row.res.hit = hit;
    row.res.slot = SLOT_W'(slot);
    row.res.evicted = evicted;
    directed_rows.push_back(row);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %p", $realtime,
                 result_word);
        mismatches++;
      end else begin
        oldest_res = pending_results.pop_front();
        if (result_word.hit !== oldest_res.hit) begin
          $display("%0t: hit mismatch, expected %0d, actual %0d", $realtime,
                   oldest_res.hit, result_word.hit);
          mismatches++;
        end
        if (result_word.slot !== oldest_res.slot) begin
          $display("%0t: slot mismatch, expected %0d, actual %0d", $realtime,
                   oldest_res.slot, result_word.slot);
          mismatches++;
        end
        if (result_word.evicted !== oldest_res.evicted) begin
          $display("%0t: evicted mismatch, expected %0d, actual %0d", $realtime,
                   oldest_res.evicted, result_word.evicted);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #120_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned       phase_items[3];
    int unsigned       insert_pct[3];
    int unsigned       roll;
    int unsigned       waited;
    cmd_t              c;
    phase_items = '{350, 350, 330};
    insert_pct  = '{80, 40, 50};

    start = 1'b0;
    cmd_word = '0;
    rst_ni = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      tag_of[i] = '0;
      live[i] = 1'b0;
      free_top[i] = SLOT_W'(i);
      fifo_ord[i] = '0;
    end
    free_depth = ENTRIES;
    fifo_head = 0;
    fifo_depth = 0;

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    add_row(OP_LOOKUP, 32'h0000_0000, 1'b1, 1'b0, 0, 1'b0);
    add_row(OP_LOOKUP, 32'hFFFF_FFFF, 1'b1, 1'b0, 0, 1'b0);
    add_row(OP_INSERT, 32'hFFFF_FFFF, 1'b1, 1'b0, ENTRIES - 1, 1'b0);
    add_row(OP_INSERT, 32'h0000_0000, 1'b1, 1'b0, ENTRIES - 2, 1'b0);
    add_row(OP_LOOKUP, 32'hFFFF_FFFF, 1'b1, 1'b1, ENTRIES - 1, 1'b0);
    add_row(OP_LOOKUP, 32'h0000_0000, 1'b1, 1'b1, ENTRIES - 2, 1'b0);
    // duplicate key: lowest slot wins
    add_row(OP_INSERT, 32'hFFFF_FFFF, 1'b1, 1'b0, ENTRIES - 3, 1'b0);
    add_row(OP_LOOKUP, 32'hFFFF_FFFF, 1'b1, 1'b1, ENTRIES - 3, 1'b0);
    add_row(OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b0, 0, 1'b0);
    add_row(OP_INSERT, 32'h8000_0000, 1'b0, 1'b0, 0, 1'b0);
    add_row(OP_INSERT, 32'h0000_0001, 1'b0, 1'b0, 0, 1'b0);
    add_row(OP_LOOKUP, 32'h8000_0000, 1'b0, 1'b0, 0, 1'b0);
    add_row(OP_LOOKUP, 32'h1234_5678, 1'b0, 1'b0, 0, 1'b0);
    add_row(OP_FLUSH,  32'h0000_0000, 1'b1, 1'b0, 0, 1'b0);
    add_row(OP_LOOKUP, 32'hFFFF_FFFF, 1'b1, 1'b0, 0, 1'b0);
    add_row(OP_INSERT, 32'hAAAA_AAAA, 1'b0, 1'b0, 0, 1'b0);
    add_row(OP_INSERT, 32'h5555_5555, 1'b0, 1'b0, 0, 1'b0);
    add_row(OP_LOOKUP, 32'h5555_5555, 1'b0, 1'b0, 0, 1'b0);
    add_row(OP_LOOKUP, 32'hAAAA_AAAA, 1'b0, 1'b0, 0, 1'b0);
    add_row(OP_UNUSED, 32'h0000_0000, 1'b1, 1'b0, 0, 1'b0);
    add_row(OP_FLUSH,  32'hFFFF_FFFF, 1'b1, 1'b0, 0, 1'b0);
    add_row(OP_FLUSH,  32'h0000_0000, 1'b1, 1'b0, 0, 1'b0);
    add_row(OP_INSERT, 32'h0000_0000, 1'b0, 1'b0, 0, 1'b0);

    foreach (directed_rows[n])
      send_word(directed_rows[n].word, directed_rows[n].typed, directed_rows[n].res, 1'b1);

    // phase 0 fills the cache and runs into evictions, the last one runs without gaps
    for (int phase = 0; phase < 3; phase++) begin
      drain_results();
      for (int n = 0; n < phase_items[phase]; n++) begin
        roll = $urandom_range(0, 999);
        c.key = $urandom;
        if ($urandom_range(0, 15) == 0) c.key = $urandom_range(0, 1) ? '1 : '0;
        if (phase > 0 && roll < 5) begin
          c.operation = OP_FLUSH;
        end else if (roll < 15) begin
          c.operation = OP_UNUSED;
        end else if ($urandom_range(0, 99) < insert_pct[phase]) begin
          c.operation = OP_INSERT;
          if (recent_keys.size() != 0 && $urandom_range(0, 3) == 0)
            c.key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        end else begin
          c.operation = OP_LOOKUP;
          if (recent_keys.size() != 0 && $urandom_range(0, 9) < 7)
            c.key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        end
        send_word(c, 1'b0, '0, phase < 2);
      end
    end

    start = 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 4 * ENTRIES) begin
      @(negedge clk_i);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $display("%0t: %0d result words never arrived, expected %p, actual none", $realtime,
               pending_results.size(), pending_results[0]);
      mismatches++;
    end
    repeat (2 * ENTRIES + 8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/fakc_pkg.sv
hw/rtl/fifo_associative_key_cache.sv
tb/sv/testbench.sv
